[hw/rtl/tbds_pkg.sv]
package tbds_pkg;

  localparam int QueueDepthDefault   = 64;
  localparam int NumQueuesDefault    = 4;
  localparam int MaxOpenPagesDefault = 4;
  localparam int PageShiftDefault    = 10;
  localparam int NumBanksDefault     = 8;

  localparam int CfgWidth   = 16;
  localparam int CfgIdxW    = 3;
  localparam int TokW       = 64;
  localparam int NowW       = 48;
  localparam int QuotaW     = 16;
  localparam int AddrW      = 32;
  localparam int SeqW       = 32;
  localparam int ReqW       = 2;

  localparam logic [TokW-1:0] TokenBias = {1'b1, {(TokW-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_ISSUE  = 2'd1,
    KIND_REPORT = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_REQUEST  = 2'd1,
    CMD_ACTIVATE = 2'd2,
    CMD_CLOSE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CAPACITY   = 3'd0,
    REG_STARVATION = 3'd1,
    REG_READY      = 3'd2,
    REG_TOKENS_EN  = 3'd3,
    REG_QUOTA0     = 3'd4,
    REG_QUOTA1     = 3'd5,
    REG_QUOTA2     = 3'd6,
    REG_QUOTA3     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFILL,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [ReqW-1:0]  req;
    logic [AddrW-1:0] addr;
    logic [SeqW-1:0]  seq;
  } entry_t;

  // control from sequencer to the cell row
  typedef struct packed {
    logic append;
    logic shift;
    logic rotate;
  } row_ctrl_t;

endpackage

[hw/rtl/tbds_if.sv]
interface tbds_in_if;
  import tbds_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [ReqW-1:0]        requester;
  logic [AddrW-1:0]       address;
  logic [NowW-1:0]        now;
  logic [15:0]            latency_cost;
  modport source (output valid, kind, requester, address, now, latency_cost, input ready);
  modport sink (input valid, kind, requester, address, now, latency_cost, output ready);
endinterface

interface tbds_out_if;
  import tbds_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [AddrW-1:0]       out_address;
  logic [ReqW-1:0]        out_requester;
  logic [SeqW-1:0]        out_sequence;
  logic                   blocked;
  modport source (output valid, command, out_address, out_requester, out_sequence, blocked,
                  input ready);
  modport sink (input valid, command, out_address, out_requester, out_sequence, blocked,
                output ready);
endinterface

[hw/rtl/tbds_cell.sv]
module tbds_cell
  import tbds_pkg::*;
(
  input  logic      clk,
  input  row_ctrl_t ctrl,
  input  logic      take_new,
  input  entry_t    new_entry,
  input  logic      skip,
  input  entry_t    from_next,
  output entry_t    entry
);

  // rotate: hand to neighbor, one step per cycle; shift: close gap at chosen slot
  always_ff @(posedge clk) begin
    if (ctrl.append && take_new) begin
      entry <= new_entry;
    end else if (ctrl.rotate || (ctrl.shift && skip)) begin
      entry <= from_next;
    end
  end

endmodule

[hw/rtl/token_bandwidth_dram_scheduler.sv]
// Flow: insert, latency report and ignored kinds pass the refill state, then load; issue
// refills the tokens of the NUM_QUEUES queues in turn, scans the QUEUE_DEPTH cells (one
// rotation of the cell row), then decides, removes the entry (request only) and loads, or
// loads right after the refill on an empty queue. Throughput: one item at a time, the next
// transfer in the cycle after loading; the output register holds it as the next is taken.
// Reset (rst, synchronous) empties queue, open pages and counters; tokens go to TokenBias.
module token_bandwidth_dram_scheduler
  import tbds_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QueueDepthDefault,
  parameter int NUM_QUEUES     = NumQueuesDefault,
  parameter int MAX_OPEN_PAGES = MaxOpenPagesDefault,
  parameter int PAGE_SHIFT     = PageShiftDefault,
  parameter int NUM_BANKS      = NumBanksDefault
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  tbds_in_if.sink             in_ch,
  tbds_out_if.source          out_ch
);

  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int NQW  = $clog2(NUM_QUEUES);
  localparam int OPW  = $clog2(MAX_OPEN_PAGES + 1);
  localparam int OIW  = (MAX_OPEN_PAGES > 1) ? $clog2(MAX_OPEN_PAGES) : 1;
  localparam int PGW  = AddrW - PAGE_SHIFT;
  localparam int BKW  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  // config
  logic [6:0]        queue_capacity;
  logic [7:0]        starvation_limit, ready_limit;
  logic              tokens_enabled;
  logic [QuotaW-1:0] quota [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity   <= 7'd64;
      starvation_limit <= 8'd10;
      ready_limit      <= 8'd3;
      tokens_enabled   <= 1'b1;
      for (int i = 0; i < 4; i++) quota[i] <= 16'd16384;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAPACITY:   queue_capacity   <= cfg_data[6:0];
        REG_STARVATION: starvation_limit <= cfg_data[7:0];
        REG_READY:      ready_limit      <= cfg_data[7:0];
        REG_TOKENS_EN:  tokens_enabled   <= cfg_data[0];
        REG_QUOTA0:     quota[0]         <= cfg_data;
        REG_QUOTA1:     quota[1]         <= cfg_data;
        REG_QUOTA2:     quota[2]         <= cfg_data;
        REG_QUOTA3:     quota[3]         <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] eff_cap;
  assign eff_cap = (32'(queue_capacity) < 32'(QUEUE_DEPTH)) ? CW'(queue_capacity)
                                                            : CW'(QUEUE_DEPTH);

  // state
  state_t            state, state_next;
  logic [CW-1:0]     occupancy;
  logic [CW-1:0]     pending [NUM_QUEUES];
  logic [TokW-1:0]   tokens [NUM_QUEUES];
  logic [SeqW-1:0]   next_seq;
  logic [NowW-1:0]   last_refill;
  logic [7:0]        starv_cnt, ready_cnt;
  logic [PGW-1:0]    open_pages [MAX_OPEN_PAGES];
  logic [OPW-1:0]    open_cnt;

  // latched item
  logic [1:0]        kind_r;
  logic [NQW-1:0]    q_r;
  logic [AddrW-1:0]  addr_r;
  logic [NowW-1:0]   now_r;
  logic [15:0]       cost_r;

  // scan
  logic [CW-1:0]     step;
  logic [QW-1:0]     best;
  entry_t            best_e;
  logic              best_rdy;
  logic [TokW-1:0]   best_tok;
  logic              ign_ready, tok_off;
  logic [NQW-1:0]    refill_q;
  logic [63:0]       prod;

  // result of the current item
  logic [1:0]        r_cmd;
  logic [AddrW-1:0]  r_addr;
  logic [ReqW-1:0]   r_req;
  logic [SeqW-1:0]   r_seq;

  // output register
  logic              ovalid;
  logic [1:0]        o_cmd;
  logic [AddrW-1:0]  o_addr;
  logic [ReqW-1:0]   o_req;
  logic [SeqW-1:0]   o_seq;
  logic              o_blk;

  // cell row: cell 0 is the head; rotation brings the entry at position step to cell 0
  entry_t    cells [QUEUE_DEPTH];
  row_ctrl_t ctrl;
  logic      skip_at [QUEUE_DEPTH];
  logic [QW-1:0] ins_pos;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int N1 = (g + 1) % QUEUE_DEPTH;
    tbds_cell u_cell (
      .clk(clk), .ctrl(ctrl), .take_new(ins_pos == QW'(g)),
      .new_entry('{req: ReqW'(q_r), addr: addr_r, seq: next_seq}),
      .skip(skip_at[g]), .from_next(cells[N1]),
      .entry(cells[g])
    );
  end

  // on removal every cell at or above the chosen slot takes its neighbor's entry
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_skip
    assign skip_at[g] = (QW'(g) >= best);
  end
  assign ins_pos = QW'(occupancy);

  function automatic logic is_open(input logic [AddrW-1:0] a,
                                   input logic [PGW-1:0] pgs [MAX_OPEN_PAGES],
                                   input logic [OPW-1:0] cnt);
    logic r;
    r = 1'b0;
    for (int k = 0; k < MAX_OPEN_PAGES; k++)
      if (OPW'(k) < cnt && pgs[k] == a[AddrW-1:PAGE_SHIFT]) r = 1'b1;
    return r;
  endfunction

  entry_t          head;
  logic [NQW-1:0]  head_q;
  logic            head_rdy;
  logic [TokW-1:0] head_tok;
  logic            more, eq_t, take;
  assign head     = cells[0];
  assign head_q   = (32'(head.req) < NUM_QUEUES) ? NQW'(head.req) : NQW'(NUM_QUEUES - 1);
  assign head_rdy = !ign_ready && is_open(head.addr, open_pages, open_cnt);
  assign head_tok = tokens[head_q];
  assign more     = !tok_off && best_tok > head_tok;
  assign eq_t     = tok_off || best_tok == head_tok;

  always_comb begin
    if (step == '0) take = 1'b1;
    else if (head_rdy) take = !(best_rdy && (more || eq_t));
    else take = !best_rdy && !(more || eq_t);
  end

  // refill product for one queue per cycle
  logic [NowW-1:0] elapsed;
  logic [QuotaW-1:0] cur_quota;
  assign elapsed   = now_r - last_refill;
  assign cur_quota = (32'(refill_q) < 4) ? quota[refill_q[1:0]] : '0;

  // decision helpers
  logic [PGW-1:0] best_pg;
  logic [BKW-1:0] best_bank;
  logic [OIW-1:0] hit_idx;
  logic           hit_any, best_open;
  logic [NQW-1:0] best_q;
  logic           hp;
  always_comb begin
    best_pg   = best_e.addr[AddrW-1:PAGE_SHIFT];
    best_bank = BKW'(best_pg % NUM_BANKS);
    best_open = is_open(best_e.addr, open_pages, open_cnt);
    best_q    = (32'(best_e.req) < NUM_QUEUES) ? NQW'(best_e.req) : NQW'(NUM_QUEUES - 1);
    hit_any   = 1'b0;
    hit_idx   = '0;
    for (int k = MAX_OPEN_PAGES - 1; k >= 0; k--)
      if (OPW'(k) < open_cnt && BKW'(open_pages[k] % NUM_BANKS) == best_bank) begin
        hit_any = 1'b1;
        hit_idx = OIW'(k);
      end
    hp = 1'b0;
    begin
      logic [NQW-1:0] bi;
      logic           bv;
      bi = '0;
      bv = 1'b0;
      for (int k = 0; k < NUM_QUEUES; k++)
        if (pending[k] != '0 && (!bv || tokens[k] > tokens[bi])) begin
          bi = NQW'(k);
          bv = 1'b1;
        end
      hp = bv && bi == best_q;
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  wire in_xfer  = in_ch.valid && in_ch.ready;
  wire out_xfer = out_ch.valid && out_ch.ready;
  wire load_out = (state == ST_OUT) && (!ovalid || out_xfer);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_REFILL;
      ST_REFILL: begin
        if (kind_r != KIND_ISSUE) state_next = ST_OUT;
        else if (32'(refill_q) == NUM_QUEUES - 1)
          state_next = (occupancy != '0) ? ST_SCAN : ST_OUT;
        ctrl.append = (kind_r == KIND_INSERT) && (occupancy < eff_cap);
      end
      ST_SCAN: begin
        ctrl.rotate = 1'b1;
        if (step == CW'(QUEUE_DEPTH - 1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: state_next = (best_open) ? ST_SHIFT : ST_OUT;
      ST_SHIFT: begin
        ctrl.shift = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_ch.kind;
      q_r    <= (32'(in_ch.requester) < NUM_QUEUES) ? NQW'(in_ch.requester)
                                                    : NQW'(NUM_QUEUES - 1);
      addr_r <= in_ch.address;
      now_r  <= in_ch.now;
      cost_r <= in_ch.latency_cost;
    end
  end

  logic [TokW-1:0] sub;
  assign sub = TokW'(cost_r) << 16;
  assign prod = 64'(elapsed) * 64'(cur_quota);
  logic [TokW:0] sum;
  assign sum = {1'b0, tokens[refill_q]} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy   <= '0;
      next_seq    <= '0;
      last_refill <= '0;
      starv_cnt   <= '0;
      ready_cnt   <= '0;
      open_cnt    <= '0;
      ovalid      <= 1'b0;
      refill_q    <= '0;
      step        <= '0;
      for (int k = 0; k < NUM_QUEUES; k++) begin
        pending[k] <= '0;
        tokens[k]  <= TokenBias;
      end
    end else begin
      if (load_out) ovalid <= 1'b1;
      else if (out_xfer) ovalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          refill_q <= '0;
          step     <= '0;
          ign_ready <= (starv_cnt >= starvation_limit) || (ready_cnt >= ready_limit);
          tok_off   <= !tokens_enabled || (starv_cnt >= starvation_limit);
          if (in_xfer) begin
            r_cmd  <= CMD_NONE;
            r_addr <= '0;
            r_req  <= '0;
            r_seq  <= '0;
          end
        end
        ST_REFILL: begin
          if (kind_r == KIND_INSERT && occupancy < eff_cap) begin
            occupancy     <= occupancy + 1'b1;
            next_seq      <= next_seq + 1'b1;
            pending[q_r]  <= pending[q_r] + 1'b1;
          end else if (kind_r == KIND_REPORT) begin
            tokens[q_r] <= (tokens[q_r] < sub) ? '0 : tokens[q_r] - sub;
          end else if (kind_r == KIND_ISSUE) begin
            if (cur_quota != '0) tokens[refill_q] <= sum[TokW] ? '1 : sum[TokW-1:0];
            refill_q <= refill_q + 1'b1;
            if (32'(refill_q) == NUM_QUEUES - 1) last_refill <= now_r;
          end
        end
        ST_SCAN: begin
          if (step < occupancy && take) begin
            best     <= QW'(step);
            best_e   <= head;
            best_rdy <= head_rdy;
            best_tok <= head_tok;
          end
          step <= step + 1'b1;
        end
        ST_DECIDE: begin
          if (best_open) begin
            r_cmd  <= CMD_REQUEST;
            r_addr <= best_e.addr;
            r_req  <= ReqW'(best_q);
            r_seq  <= best_e.seq;
            if (best == '0) begin
              starv_cnt <= '0;
              ready_cnt <= '0;
            end else begin
              starv_cnt <= (starv_cnt == 8'hFF) ? starv_cnt : starv_cnt + 1'b1;
              ready_cnt <= hp ? '0 : ((ready_cnt == 8'hFF) ? ready_cnt : ready_cnt + 1'b1);
            end
            if (pending[best_q] != '0) pending[best_q] <= pending[best_q] - 1'b1;
          end else if (hit_any || 32'(open_cnt) >= MAX_OPEN_PAGES) begin
            r_cmd  <= CMD_CLOSE;
            r_addr <= AddrW'(open_pages[hit_any ? hit_idx : '0]) << PAGE_SHIFT;
          end else begin
            r_cmd  <= CMD_ACTIVATE;
            r_addr <= AddrW'(best_pg) << PAGE_SHIFT;
            open_pages[OIW'(open_cnt)] <= best_pg;
            open_cnt <= open_cnt + 1'b1;
          end
          if (!best_open && (hit_any || 32'(open_cnt) >= MAX_OPEN_PAGES)) begin
            for (int k = 0; k < MAX_OPEN_PAGES - 1; k++)
              if (OIW'(k) >= (hit_any ? hit_idx : OIW'(0)))
                open_pages[k] <= open_pages[k + 1];
            open_cnt <= open_cnt - 1'b1;
          end
        end
        ST_SHIFT: begin
          occupancy <= occupancy - 1'b1;
        end
        ST_OUT: begin
          if (load_out) begin
            o_cmd  <= r_cmd;
            o_addr <= r_addr;
            o_req  <= r_req;
            o_seq  <= r_seq;
            o_blk  <= occupancy >= eff_cap;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = ovalid;
  assign out_ch.command       = o_cmd;
  assign out_ch.out_address   = o_addr;
  assign out_ch.out_requester = o_req;
  assign out_ch.out_sequence  = o_seq;
  assign out_ch.blocked       = o_blk;

endmodule
